@@ rtl/core/xess_pkg.sv @@
// shared types, codes and character constants of the xml element span scanner
`default_nettype none

package xess_pkg;

  // span kinds reported on the result channel
  localparam logic [1:0] KIND_AUTHOR = 2'd0;
  localparam logic [1:0] KIND_TITLE  = 2'd1;
  localparam logic [1:0] KIND_KEY    = 2'd2;

  // characters the scanner looks for
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_K     = 8'h6B;

  // keyword lengths and index width
  localparam int unsigned       MI_W       = 3;
  localparam logic [MI_W-1:0]   LEN_AUTHOR = 3'd6;
  localparam logic [MI_W-1:0]   LEN_TITLE  = 3'd5;
  localparam logic [MI_W-1:0]   LEN_KEY    = 3'd4;

  // scan modes, one-hot
  typedef enum logic [8:0] {
    M_IDLE    = 9'b000000001,
    M_LT      = 9'b000000010,
    M_NAME    = 9'b000000100,
    M_TAGREST = 9'b000001000,
    M_TEXT    = 9'b000010000,
    M_KEY     = 9'b000100000,
    M_KQ1     = 9'b001000000,
    M_KQ2     = 9'b010000000,
    M_KSKIP   = 9'b100000000
  } mode_t;

  // strobes from the controller to the name and history buffers
  typedef struct packed {
    logic shift;
    logic append;
  } buf_ctl_t;

  // one finished span
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] start;
    logic [31:0] length;
    logic        ovf;
  } span_t;

  // character of "author" or "title" at an index
  function automatic logic [7:0] tag_char(input logic [1:0] kind, input logic [MI_W-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (kind == KIND_AUTHOR) begin
      unique case (idx)
        3'd0: ch = 8'h61;
        3'd1: ch = 8'h75;
        3'd2: ch = 8'h74;
        3'd3: ch = 8'h68;
        3'd4: ch = 8'h6F;
        3'd5: ch = 8'h72;
        default: ch = 8'h00;
      endcase
    end else begin
      unique case (idx)
        3'd0: ch = 8'h74;
        3'd1: ch = 8'h69;
        3'd2: ch = 8'h74;
        3'd3: ch = 8'h6C;
        3'd4: ch = 8'h65;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  // character of "key=" at an index
  function automatic logic [7:0] key_char(input logic [MI_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = 8'h6B;
      3'd1: ch = 8'h65;
      3'd2: ch = 8'h79;
      3'd3: ch = 8'h3D;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/xess_if.sv @@
// valid/ready channel interfaces for document bytes and finished spans
`default_nettype none

interface xess_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_document;

  modport source (output valid, output data_byte, output first_of_document, input ready);
  modport sink   (input valid, input data_byte, input first_of_document, output ready);
endinterface

interface xess_span_if;
  logic        valid;
  logic        ready;
  logic [1:0]  span_kind;
  logic [31:0] span_start;
  logic [31:0] span_length;
  logic        name_overflow;

  modport source (output valid, output span_kind, output span_start, output span_length,
                  output name_overflow, input ready);
  modport sink   (input valid, input span_kind, input span_start, input span_length,
                  input name_overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xess_close_match.sv @@
// element name buffer, byte history and close tag window compare
`default_nettype none

module xess_close_match #(
  parameter int MAX_NAME_BYTES = 26
) (
  input  logic                                  clk,
  input  xess_pkg::buf_ctl_t                    ctl,
  input  logic [7:0]                            data_byte,
  input  logic [$clog2(MAX_NAME_BYTES+1)-1:0]   name_len,
  output logic                                  window_ok
);

  localparam int NLW   = $clog2(MAX_NAME_BYTES + 1);
  localparam int HDEP  = MAX_NAME_BYTES + 2;
  localparam int HW    = $clog2(HDEP);

  // name kept newest byte first, history of earlier bytes newest first
  logic [7:0]       name_rev [MAX_NAME_BYTES];
  logic [7:0]       hist     [HDEP];
  logic             name_ok;
  logic [HDEP-1:0]  slash_hit;
  logic [HDEP-1:0]  lt_hit;
  logic [HW-1:0]    slash_idx;
  logic [HW-1:0]    lt_idx;

  // name capture
  always_ff @(posedge clk) begin
    if (ctl.append) begin
      name_rev[0] <= data_byte;
      for (int i = 1; i < MAX_NAME_BYTES; i++) begin
        name_rev[i] <= name_rev[i-1];
      end
    end
  end

  // byte history
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      hist[0] <= data_byte;
      for (int i = 1; i < HDEP; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  // name bytes line up with the most recent history bytes
  always_comb begin
    name_ok = 1'b1;
    for (int i = 0; i < MAX_NAME_BYTES; i++) begin
      if ((NLW'(i) < name_len) && (hist[i] != name_rev[i])) begin
        name_ok = 1'b0;
      end
    end
  end

  // slash and open bracket ahead of the name
  always_comb begin
    for (int i = 0; i < HDEP; i++) begin
      slash_hit[i] = (hist[i] == xess_pkg::CH_SLASH);
      lt_hit[i]    = (hist[i] == xess_pkg::CH_LT);
    end
  end

  assign slash_idx = HW'(name_len);
  assign lt_idx    = HW'(name_len) + HW'(1);
  assign window_ok = name_ok && slash_hit[slash_idx] && lt_hit[lt_idx];

endmodule

`default_nettype wire

@@ rtl/core/xess_scan_ctrl.sv @@
// scan mode sequencing, position and span bookkeeping
`default_nettype none

module xess_scan_ctrl #(
  parameter int MAX_NAME_BYTES = 26
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  logic [7:0]                           data_byte,
  input  logic                                 first_of_document,
  input  logic                                 window_ok,
  output xess_pkg::buf_ctl_t                   buf_ctl,
  output logic [$clog2(MAX_NAME_BYTES+1)-1:0]  name_len,
  output xess_pkg::span_t                      span
);

  localparam int NLW  = $clog2(MAX_NAME_BYTES + 1);
  localparam int TCW  = $clog2(MAX_NAME_BYTES + 3);
  localparam int MIW  = xess_pkg::MI_W;

  xess_pkg::mode_t   mode, mode_next, mode_eff, idle_mode;
  logic [31:0]       pos, pos_next, pos_eff;
  logic [MIW-1:0]    mi, mi_next, mi_eff, idle_mi;
  logic [NLW-1:0]    nl, nl_next;
  logic [31:0]       span_begin, span_begin_next;
  logic [1:0]        kind, kind_next;
  logic              ovf, ovf_next;
  logic [31:0]       tlen, tlen_next;
  logic [TCW-1:0]    tcnt, tcnt_next;
  logic              append;
  logic              close_hit;
  logic [MIW-1:0]    word_len;
  logic [7:0]        c;

  assign c = data_byte;

  // start of document restarts the scan
  assign mode_eff = first_of_document ? xess_pkg::M_IDLE : mode;
  assign mi_eff   = first_of_document ? '0 : mi;
  assign pos_eff  = first_of_document ? '0 : pos;

  // outcome of this byte when scanned in idle mode
  always_comb begin
    if (c == xess_pkg::CH_LT) begin
      idle_mode = xess_pkg::M_LT;
      idle_mi   = '0;
    end else if (c == xess_pkg::CH_K) begin
      idle_mode = xess_pkg::M_KEY;
      idle_mi   = MIW'(1);
    end else begin
      idle_mode = xess_pkg::M_IDLE;
      idle_mi   = '0;
    end
  end

  assign word_len  = (kind == xess_pkg::KIND_AUTHOR) ? xess_pkg::LEN_AUTHOR : xess_pkg::LEN_TITLE;
  assign close_hit = (c == xess_pkg::CH_GT) && window_ok &&
                     (tcnt >= (TCW'(nl) + TCW'(2)));

  // next state and span result
  always_comb begin
    mode_next       = mode_eff;
    mi_next         = mi_eff;
    nl_next         = nl;
    span_begin_next = span_begin;
    kind_next       = kind;
    ovf_next        = ovf;
    pos_next        = pos_eff + 32'd1;
    tlen_next       = tlen + 32'd1;
    tcnt_next       = (tcnt == TCW'(MAX_NAME_BYTES + 2)) ? tcnt : tcnt + TCW'(1);
    append          = 1'b0;
    span.valid      = 1'b0;
    span.kind       = kind;
    span.start      = span_begin;
    span.length     = tlen;
    span.ovf        = 1'b0;

    unique case (mode_eff)
      xess_pkg::M_IDLE: begin
        mode_next = idle_mode;
        mi_next   = idle_mi;
      end
      xess_pkg::M_LT: begin
        if (mi_eff == '0) begin
          if (c == xess_pkg::CH_A || c == xess_pkg::CH_T) begin
            kind_next = (c == xess_pkg::CH_A) ? xess_pkg::KIND_AUTHOR : xess_pkg::KIND_TITLE;
            nl_next   = NLW'(1);
            ovf_next  = 1'b0;
            append    = 1'b1;
            mi_next   = MIW'(1);
          end else begin
            mode_next = idle_mode;
            mi_next   = idle_mi;
          end
        end else if (c == xess_pkg::tag_char(kind, mi_eff)) begin
          append  = 1'b1;
          nl_next = nl + NLW'(1);
          mi_next = mi_eff + MIW'(1);
          if ((mi_eff + MIW'(1)) == word_len) begin
            mode_next = xess_pkg::M_NAME;
          end
        end else begin
          mode_next = idle_mode;
          mi_next   = idle_mi;
        end
      end
      xess_pkg::M_NAME: begin
        if (c == xess_pkg::CH_SPACE) begin
          mode_next = xess_pkg::M_TAGREST;
        end else if (c == xess_pkg::CH_GT) begin
          mode_next       = xess_pkg::M_TEXT;
          span_begin_next = pos_eff + 32'd1;
          tlen_next       = '0;
          tcnt_next       = '0;
          mi_next         = '0;
        end else if (nl < NLW'(MAX_NAME_BYTES)) begin
          append  = 1'b1;
          nl_next = nl + NLW'(1);
        end else begin
          ovf_next = 1'b1;
        end
      end
      xess_pkg::M_TAGREST: begin
        if (c == xess_pkg::CH_GT) begin
          mode_next       = xess_pkg::M_TEXT;
          span_begin_next = pos_eff + 32'd1;
          tlen_next       = '0;
          tcnt_next       = '0;
          mi_next         = '0;
        end
      end
      xess_pkg::M_TEXT: begin
        if (close_hit) begin
          span.valid  = 1'b1;
          span.length = tlen - (32'(nl) + 32'd2);
          span.ovf    = ovf;
          mode_next   = xess_pkg::M_IDLE;
          mi_next     = '0;
        end
      end
      xess_pkg::M_KEY: begin
        if (c == xess_pkg::key_char(mi_eff)) begin
          mi_next = mi_eff + MIW'(1);
          if ((mi_eff + MIW'(1)) == xess_pkg::LEN_KEY) begin
            mode_next = xess_pkg::M_KQ1;
          end
        end else begin
          mode_next = idle_mode;
          mi_next   = idle_mi;
        end
      end
      xess_pkg::M_KQ1: begin
        if (c == xess_pkg::CH_QUOTE) begin
          span_begin_next = pos_eff + 32'd1;
          tlen_next       = '0;
          mode_next       = xess_pkg::M_KQ2;
        end
      end
      xess_pkg::M_KQ2: begin
        if (c == xess_pkg::CH_QUOTE) begin
          span.valid = 1'b1;
          span.kind  = xess_pkg::KIND_KEY;
          mode_next  = xess_pkg::M_KSKIP;
        end
      end
      default: begin
        mode_next = xess_pkg::M_IDLE;
        mi_next   = '0;
      end
    endcase
  end

  assign buf_ctl.shift  = step;
  assign buf_ctl.append = step && append;
  assign name_len       = nl;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= xess_pkg::M_IDLE;
      pos        <= '0;
      mi         <= '0;
      nl         <= '0;
      span_begin <= '0;
      kind       <= xess_pkg::KIND_AUTHOR;
      ovf        <= 1'b0;
      tlen       <= '0;
      tcnt       <= '0;
    end else if (step) begin
      mode       <= mode_next;
      pos        <= pos_next;
      mi         <= mi_next;
      nl         <= nl_next;
      span_begin <= span_begin_next;
      kind       <= kind_next;
      ovf        <= ovf_next;
      tlen       <= tlen_next;
      tcnt       <= tcnt_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/xml_element_span_scanner_unit.sv @@
// top level of the xml element span scanner: input stage, scan core, result register
//
// The block reads an XML document one byte per item on byte_in and reports
// author text, title text and key="..." value spans on span_out, each as a
// kind, a start offset and a length, plus a flag for element names longer
// than MAX_NAME_BYTES. first_of_document on a byte restarts the offset at
// zero and drops any scan in progress.
// Both channels are valid/ready; an item moves when both are high.
// Each byte is registered in the input register, then scanned, and a span that
// closes on it is registered in the result register and shown on span_out.
// Throughput is one byte per cycle while span_out is not stalled; the rate is
// set by the scan step between the input register and the result register.
// When the receiver stalls, the finished span waits in the result register
// and the byte behind it waits in the input register; byte_in.ready drops
// only when both are held.
// Reset (rst, synchronous) empties both registers, sets the scan to idle
// and the offset to zero.

`default_nettype none

module xml_element_span_scanner_unit #(
  parameter int MAX_NAME_BYTES = 26
) (
  input  logic             clk,
  input  logic             rst,
  xess_byte_if.sink        byte_in,
  xess_span_if.source      span_out
);

  localparam int NLW = $clog2(MAX_NAME_BYTES + 1);

  logic               s1_valid;
  logic [7:0]         s1_data;
  logic               s1_first;
  logic               step;
  logic               o_valid;
  xess_pkg::span_t    span;
  xess_pkg::span_t    o_span;
  xess_pkg::buf_ctl_t buf_ctl;
  logic [NLW-1:0]     name_len;
  logic               window_ok;

  // scan the held byte when the result register can take its outcome
  assign step          = s1_valid && (!o_valid || span_out.ready);
  assign byte_in.ready = !s1_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      s1_data  <= byte_in.data_byte;
      s1_first <= byte_in.first_of_document;
    end
  end

  xess_scan_ctrl #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .data_byte        (s1_data),
    .first_of_document(s1_first),
    .window_ok        (window_ok),
    .buf_ctl          (buf_ctl),
    .name_len         (name_len),
    .span             (span)
  );

  xess_close_match #(
    .MAX_NAME_BYTES(MAX_NAME_BYTES)
  ) u_match (
    .clk      (clk),
    .ctl      (buf_ctl),
    .data_byte(s1_data),
    .name_len (name_len),
    .window_ok(window_ok)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (step) begin
      o_valid <= span.valid;
    end else if (span_out.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && span.valid) begin
      o_span <= span;
    end
  end

  assign span_out.valid         = o_valid;
  assign span_out.span_kind     = o_span.kind;
  assign span_out.span_start    = o_span.start;
  assign span_out.span_length   = o_span.length;
  assign span_out.name_overflow = o_span.ovf;

  // a held byte behind a stalled span must block new items
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && o_valid && !span_out.ready) |-> !byte_in.ready)
    else $error("input accepted while both stages are held");

  // key spans never report a long name
  a_key_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (span_out.valid && (span_out.span_kind == xess_pkg::KIND_KEY)) |-> !span_out.name_overflow)
    else $error("key span carries name overflow");

  // a new span appears only after a scan step
  a_span_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(step))
    else $error("span shown without a scan step");

endmodule

`default_nettype wire
